/* sv/wgc_pkg.sv */
// ----------------------------------------------------------------------------
// wgc_pkg
// Shared types, constants and helpers of the waypoint go-to-goal controller.
// ----------------------------------------------------------------------------
package wgc_pkg;

  localparam int MAX_WAYPOINTS    = 8;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int WP_IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int ITER_W   = $clog2(ANGLE_ITERATIONS);

  localparam logic signed [34:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [34:0] ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [32:0] CORDIC_K    = 33'sd652032874;

  localparam logic [15:0] LINEAR_GAIN_RST  = 16'd2048;
  localparam logic [15:0] ANGULAR_GAIN_RST = 16'd2048;
  localparam logic [14:0] THRESHOLD_RST    = 15'd26;
  localparam logic [2:0]  LAST_WP_RST      = 3'd5;

  typedef enum logic [1:0] {
    CFG_LINEAR_GAIN  = 2'd0,
    CFG_ANGULAR_GAIN = 2'd1,
    CFG_THRESHOLD    = 2'd2,
    CFG_LAST_WP      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ITEM_WRITE = 1'b0,
    ITEM_POSE  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [2:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [14:0] heading;
  } item_t;

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
    logic [14:0] arrive_threshold;
    logic [2:0]  last_waypoint;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_MUL_Y,
    ST_SUM,
    ST_GAIN,
    ST_FIN,
    ST_OUT
  } state_t;

  function automatic logic signed [34:0] atan_entry(input logic [4:0] idx);
    logic signed [34:0] v;
    case (idx)
      5'd0:  v = 35'sd843314856;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043836;
      5'd3:  v = 35'sd133525158;
      5'd4:  v = 35'sd67021686;
      5'd5:  v = 35'sd33543515;
      5'd6:  v = 35'sd16775850;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194282;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048575;
      5'd11: v = 35'sd524287;
      5'd12: v = 35'sd262143;
      5'd13: v = 35'sd131071;
      5'd14: v = 35'sd65535;
      5'd15: v = 35'sd32767;
      5'd16: v = 35'sd16383;
      5'd17: v = 35'sd8191;
      5'd18: v = 35'sd4095;
      5'd19: v = 35'sd2047;
      5'd20: v = 35'sd1023;
      5'd21: v = 35'sd511;
      5'd22: v = 35'sd255;
      5'd23: v = 35'sd127;
      5'd24: v = 35'sd63;
      5'd25: v = 35'sd31;
      5'd26: v = 35'sd15;
      5'd27: v = 35'sd7;
      5'd28: v = 35'sd3;
      5'd29: v = 35'sd1;
      default: v = 35'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* sv/wgc_front.sv */
// ----------------------------------------------------------------------------
// wgc_front
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wgc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [2:0]          slot,
  input  logic signed [15:0]  coord_x,
  input  logic signed [15:0]  coord_y,
  input  logic signed [14:0]  heading,
  output logic                head_valid,
  output wgc_pkg::item_t      head,
  input  logic                pop
);

  wgc_pkg::item_t entries [2];
  wgc_pkg::item_t item;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    item.kind    = func ? wgc_pkg::ITEM_POSE : wgc_pkg::ITEM_WRITE;
    item.slot    = slot;
    item.x       = coord_x;
    item.y       = coord_y;
    item.heading = heading;
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= item;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/wgc_cordic.sv */
// ----------------------------------------------------------------------------
// wgc_cordic
// Iterative CORDIC: vectoring for atan2 of the offset and rotation for
// cos and sin of the heading, run side by side, one step per cycle.
// ----------------------------------------------------------------------------
module wgc_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [16:0]  dx,
  input  logic signed [16:0]  dy,
  input  logic signed [14:0]  hd,
  output logic                done,
  output logic signed [34:0]  atan_z,
  output logic signed [32:0]  cos_v,
  output logic signed [32:0]  sin_v
);

  logic signed [35:0] ax, ay, ax0, ay0;
  logic signed [34:0] az, az0;
  logic signed [32:0] sx, sy;
  logic signed [34:0] sz, sz0, hz;
  logic signed [34:0] step_ang;
  logic               neg, neg0, zero_off, busy;
  logic [wgc_pkg::ITER_W-1:0] cnt;

  always_comb begin
    ax0 = $signed({{5{dx[16]}}, dx, 14'b0});
    ay0 = $signed({{5{dy[16]}}, dy, 14'b0});
    az0 = '0;
    if (dx < 0) begin
      az0 = (dy >= 0) ? wgc_pkg::ANG_PI : -wgc_pkg::ANG_PI;
      ax0 = -ax0;
      ay0 = -ay0;
    end
    hz   = $signed({{2{hd[14]}}, hd, 18'b0});
    sz0  = hz;
    neg0 = 1'b0;
    if (hz > wgc_pkg::ANG_HALF_PI) begin
      sz0  = hz - wgc_pkg::ANG_PI;
      neg0 = 1'b1;
    end else if (hz < -wgc_pkg::ANG_HALF_PI) begin
      sz0  = hz + wgc_pkg::ANG_PI;
      neg0 = 1'b1;
    end
    step_ang = wgc_pkg::atan_entry(5'(cnt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        ax       <= ax0;
        ay       <= ay0;
        az       <= az0;
        zero_off <= (dx == 0) && (dy == 0);
        sx       <= wgc_pkg::CORDIC_K;
        sy       <= '0;
        sz       <= sz0;
        neg      <= neg0;
      end else if (busy) begin
        if (ay > 0) begin
          ax <= ax + (ay >>> cnt);
          ay <= ay - (ax >>> cnt);
          az <= az + step_ang;
        end else begin
          ax <= ax - (ay >>> cnt);
          ay <= ay + (ax >>> cnt);
          az <= az - step_ang;
        end
        if (sz >= 0) begin
          sx <= sx - (sy >>> cnt);
          sy <= sy + (sx >>> cnt);
          sz <= sz - step_ang;
        end else begin
          sx <= sx + (sy >>> cnt);
          sy <= sy - (sx >>> cnt);
          sz <= sz + step_ang;
        end
        cnt <= cnt + 1'b1;
        if (cnt == wgc_pkg::ITER_W'(wgc_pkg::ANGLE_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign atan_z = zero_off ? '0 : az;
  assign cos_v  = neg ? -sx : sx;
  assign sin_v  = neg ? -sy : sy;

endmodule

/* sv/wgc_back.sv */
// ----------------------------------------------------------------------------
// wgc_back
// Executes queued transactions: waypoint table writes and pose samples,
// with the control law and the result register.
// ----------------------------------------------------------------------------
module wgc_back (
  input  logic                clk,
  input  logic                rst,
  input  wgc_pkg::cfg_t       cfg,
  input  logic                head_valid,
  input  wgc_pkg::item_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  linear_cmd,
  output logic signed [15:0]  angular_cmd,
  output logic                cmd_valid,
  output logic                arrived,
  output logic [3:0]          waypoint_now,
  output logic                finished
);

  wgc_pkg::state_t state, state_next;

  logic signed [15:0] goal_x [wgc_pkg::MAX_WAYPOINTS];
  logic signed [15:0] goal_y [wgc_pkg::MAX_WAYPOINTS];
  logic [3:0]         goal_index;

  logic signed [15:0] px, py;
  logic signed [14:0] hd;
  logic signed [16:0] dx, dy;
  logic signed [16:0] dx_in, dy_in;
  logic signed [15:0] gx, gy;
  logic signed [50:0] prod_x, prod_y;
  logic signed [50:0] dot;
  logic signed [20:0] proj;
  logic signed [17:0] alpha;
  logic signed [37:0] lin_prod;
  logic signed [34:0] ang_prod;
  logic signed [15:0] res_lin, res_ang;
  logic               res_cmd, res_arr;
  logic signed [34:0] zr;
  logic signed [38:0] lin_r;
  logic signed [35:0] ang_r;

  logic cordic_done;
  logic signed [34:0] atan_z;
  logic signed [32:0] cos_v, sin_v;

  logic tbl_we, load_pose, cordic_start, emit, is_done_goal, out_free;

  assign is_done_goal = (goal_index > {1'b0, cfg.last_waypoint});
  assign out_free     = !out_valid || !out_stall;

  always_comb begin
    gx = '0;
    gy = '0;
    if (goal_index < 4'(wgc_pkg::MAX_WAYPOINTS)) begin
      gx = goal_x[goal_index[wgc_pkg::WP_IDX_W-1:0]];
      gy = goal_y[goal_index[wgc_pkg::WP_IDX_W-1:0]];
    end
  end

  assign dx_in = {gx[15], gx} - {px[15], px};
  assign dy_in = {gy[15], gy} - {py[15], py};

  wgc_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cordic_start),
    .dx     (dx_in),
    .dy     (dy_in),
    .hd     (hd),
    .done   (cordic_done),
    .atan_z (atan_z),
    .cos_v  (cos_v),
    .sin_v  (sin_v)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wgc_pkg::ST_IDLE: begin
        if (head_valid && head.kind == wgc_pkg::ITEM_POSE) begin
          state_next = wgc_pkg::ST_LOAD;
        end
      end
      wgc_pkg::ST_LOAD:  state_next = is_done_goal ? wgc_pkg::ST_OUT : wgc_pkg::ST_ITER;
      wgc_pkg::ST_ITER:  state_next = cordic_done ? wgc_pkg::ST_MUL_Y : wgc_pkg::ST_ITER;
      wgc_pkg::ST_MUL_Y: state_next = wgc_pkg::ST_SUM;
      wgc_pkg::ST_SUM:   state_next = wgc_pkg::ST_GAIN;
      wgc_pkg::ST_GAIN:  state_next = wgc_pkg::ST_FIN;
      wgc_pkg::ST_FIN:   state_next = wgc_pkg::ST_OUT;
      wgc_pkg::ST_OUT:   state_next = out_free ? wgc_pkg::ST_IDLE : wgc_pkg::ST_OUT;
      default:           state_next = wgc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop          = 1'b0;
    tbl_we       = 1'b0;
    load_pose    = 1'b0;
    cordic_start = 1'b0;
    emit         = 1'b0;
    case (state)
      wgc_pkg::ST_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          tbl_we    = (head.kind == wgc_pkg::ITEM_WRITE);
          load_pose = (head.kind == wgc_pkg::ITEM_POSE);
        end
      end
      wgc_pkg::ST_LOAD: cordic_start = !is_done_goal;
      wgc_pkg::ST_OUT:  emit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    dot   = prod_x + prod_y + (51'sd1 <<< 29);
    zr    = atan_z + (35'sd1 <<< 17);
    lin_r = {lin_prod[37], lin_prod} + 39'sd2048;
    ang_r = {ang_prod[34], ang_prod} + 36'sd2048;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wgc_pkg::ST_IDLE;
      goal_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (tbl_we && {1'b0, head.slot} < 4'(wgc_pkg::MAX_WAYPOINTS)) begin
        goal_x[head.slot[wgc_pkg::WP_IDX_W-1:0]] <= head.x;
        goal_y[head.slot[wgc_pkg::WP_IDX_W-1:0]] <= head.y;
      end
      if (load_pose) begin
        px <= head.x;
        py <= head.y;
        hd <= head.heading;
      end
      case (state)
        wgc_pkg::ST_LOAD: begin
          dx      <= dx_in;
          dy      <= dy_in;
          res_lin <= '0;
          res_ang <= '0;
          res_cmd <= 1'b0;
          res_arr <= 1'b0;
        end
        wgc_pkg::ST_ITER: begin
          if (cordic_done) begin
            prod_x <= 51'(dx) * 51'(cos_v);
          end
        end
        wgc_pkg::ST_MUL_Y: prod_y <= 51'(dy) * 51'(sin_v);
        wgc_pkg::ST_SUM: begin
          proj  <= dot[50:30];
          alpha <= 18'(zr >>> 18) - {{3{hd[14]}}, hd};
        end
        wgc_pkg::ST_GAIN: begin
          lin_prod <= $signed({1'b0, cfg.linear_gain}) * 38'(proj);
          ang_prod <= $signed({1'b0, cfg.angular_gain}) * 35'(alpha);
        end
        wgc_pkg::ST_FIN: begin
          if (proj <= $signed({6'b0, cfg.arrive_threshold})) begin
            goal_index <= goal_index + 4'd1;
            res_arr    <= 1'b1;
          end else begin
            res_lin <= wgc_pkg::sat16(40'(lin_r >>> 12));
            res_ang <= wgc_pkg::sat16(40'(ang_r >>> 12));
            res_cmd <= 1'b1;
          end
        end
        default: ;
      endcase
      if (emit) begin
        out_valid    <= 1'b1;
        linear_cmd   <= res_lin;
        angular_cmd  <= res_ang;
        cmd_valid    <= res_cmd;
        arrived      <= res_arr;
        waypoint_now <= goal_index;
        finished     <= is_done_goal;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/waypoint_go_to_goal_controller_unit.sv */
// ----------------------------------------------------------------------------
// waypoint_go_to_goal_controller_unit
// Proportional go-to-goal controller stepping through a waypoint table.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   func slot coord_x coord_y heading
//   out      output     out_valid / out_stall linear_cmd angular_cmd cmd_valid
//                                             arrived waypoint_now finished
//   cfg      input      cfg_valid / cfg_ready cfg_index cfg_data
//
// a pose sample runs load, the 16-step cordic loop, mul_y, sum, gain, fin
// and out; a finished sample skips to out; a table write ends in idle.
// rst is synchronous; it clears the goal index and loads default gains.
// the two-entry input queue takes transactions while the back end works;
// a stalled result holds the back end in its output state.
// ----------------------------------------------------------------------------
module waypoint_go_to_goal_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [2:0]          slot,
  input  logic signed [15:0]  coord_x,
  input  logic signed [15:0]  coord_y,
  input  logic signed [14:0]  heading,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  linear_cmd,
  output logic signed [15:0]  angular_cmd,
  output logic                cmd_valid,
  output logic                arrived,
  output logic [3:0]          waypoint_now,
  output logic                finished,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  wgc_pkg::cfg_t  cfg;
  wgc_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_gain      <= wgc_pkg::LINEAR_GAIN_RST;
      cfg.angular_gain     <= wgc_pkg::ANGULAR_GAIN_RST;
      cfg.arrive_threshold <= wgc_pkg::THRESHOLD_RST;
      cfg.last_waypoint    <= wgc_pkg::LAST_WP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (wgc_pkg::cfg_idx_t'(cfg_index))
        wgc_pkg::CFG_LINEAR_GAIN:  cfg.linear_gain      <= cfg_data;
        wgc_pkg::CFG_ANGULAR_GAIN: cfg.angular_gain     <= cfg_data;
        wgc_pkg::CFG_THRESHOLD:    cfg.arrive_threshold <= cfg_data[14:0];
        wgc_pkg::CFG_LAST_WP:      cfg.last_waypoint    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  wgc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .slot       (slot),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .heading    (heading),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  wgc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .linear_cmd   (linear_cmd),
    .angular_cmd  (angular_cmd),
    .cmd_valid    (cmd_valid),
    .arrived      (arrived),
    .waypoint_now (waypoint_now),
    .finished     (finished)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the waypoint go-to-goal controller. Fills the
// waypoint table, runs directed poses over the field and register extremes,
// then random streams of table writes and poses, mostly aimed at the current goal,
// under varying valid/stall pressure. Every result transaction is checked against
// a cycle-free model built on the same 16-step fixed-point cordic.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic               cmd;
    logic               arr;
    logic [3:0]         wp;
    logic               fin;
  } steer_t;

  class waypoint_scoreboard;
    int fails;
    logic signed [15:0] goal_x[8];
    logic signed [15:0] goal_y[8];
    int unsigned goal_idx;
    longint lin_gain, ang_gain, arrive_thr;
    int unsigned last_wp;
    steer_t expected_steer[$];
    longint arctan_lut[16] = '{843314856, 497837829, 263043836, 133525158,
      67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
      524287, 262143, 131071, 65535, 32767};

    function new();
      fails = 0;
      goal_idx = 0;
      lin_gain = 2048;
      ang_gain = 2048;
      arrive_thr = 26;
      last_wp = 5;
    endfunction

    function void set_reg(wgc_pkg::cfg_idx_t idx, logic [15:0] d);
      case (idx)
        wgc_pkg::CFG_LINEAR_GAIN:  lin_gain = d;
        wgc_pkg::CFG_ANGULAR_GAIN: ang_gain = d;
        wgc_pkg::CFG_THRESHOLD:    arrive_thr = d[14:0];
        wgc_pkg::CFG_LAST_WP:      last_wp = d[2:0];
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint bearing(longint dy, longint dx);
      longint x, y, z, t;
      x = dx * 16384;
      y = dy * 16384;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += arctan_lut[i];
        end else begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= arctan_lut[i];
        end
      end
      return z;
    endfunction

    function void rotate(longint z, output longint c, output longint s);
      longint x, y, t;
      bit neg;
      x = 652032874;
      y = 0;
      neg = 0;
      while (z > 64'sd1686629713) begin z -= 64'sd3373259426; neg = !neg; end
      while (z < -64'sd1686629713) begin z += 64'sd3373259426; neg = !neg; end
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= arctan_lut[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += arctan_lut[i];
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function void note_input(wgc_pkg::item_t it);
      steer_t e;
      longint dx, dy, alpha, c, s, proj;
      if (it.kind == wgc_pkg::ITEM_WRITE) begin
        goal_x[it.slot] = it.x;
        goal_y[it.slot] = it.y;
        return;
      end
      e = '{0, 0, 0, 0, 0, 0};
      if (goal_idx <= last_wp) begin
        dx = longint'(goal_x[goal_idx]) - longint'(it.x);
        dy = longint'(goal_y[goal_idx]) - longint'(it.y);
        alpha = round_shift(bearing(dy, dx), 18) - longint'(it.heading);
        rotate(longint'(it.heading) * 262144, c, s);
        proj = round_shift(dx * c + dy * s, 30);
        if (proj <= arrive_thr) begin
          goal_idx = (goal_idx + 1) & 15;
          e.arr = 1;
        end else begin
          e.lin = 16'(clip16(round_shift(lin_gain * proj, 12)));
          e.ang = 16'(clip16(round_shift(ang_gain * alpha, 12)));
          e.cmd = 1;
        end
      end
      e.wp = goal_idx[3:0];
      e.fin = goal_idx > last_wp;
      expected_steer.push_back(e);
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check(steer_t got);
      steer_t e;
      if (expected_steer.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      e = expected_steer.pop_front();
      if (got.lin !== e.lin) report($sformatf("linear_cmd %0d exp %0d", got.lin, e.lin));
      if (got.ang !== e.ang) report($sformatf("angular_cmd %0d exp %0d", got.ang, e.ang));
      if (got.cmd !== e.cmd) report($sformatf("cmd_valid %0b exp %0b", got.cmd, e.cmd));
      if (got.arr !== e.arr) report($sformatf("arrived %0b exp %0b", got.arr, e.arr));
      if (got.wp !== e.wp) report($sformatf("waypoint_now %0d exp %0d", got.wp, e.wp));
      if (got.fin !== e.fin) report($sformatf("finished %0b exp %0b", got.fin, e.fin));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic func = 0;
  logic [2:0] slot = 0;
  logic signed [15:0] coord_x = 0;
  logic signed [15:0] coord_y = 0;
  logic signed [14:0] heading = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] linear_cmd;
  logic signed [15:0] angular_cmd;
  logic cmd_valid;
  logic arrived;
  logic [3:0] waypoint_now;
  logic finished;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  waypoint_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit pressure_req = 0;
  bit pressure_done = 0;
  int hold_left = 0;
  int cycles = 0;
  bit in_low = 1;

  waypoint_go_to_goal_controller_unit DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL waypoint_go_to_goal_controller_unit");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (pressure_req && !pressure_done) begin
      pressure_done <= 1;
      hold_left <= 400;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{linear_cmd, angular_cmd, cmd_valid, arrived, waypoint_now, finished});
  end

  function automatic wgc_pkg::item_t mk(wgc_pkg::item_kind_t k, int s, int x, int y, int h);
    wgc_pkg::item_t it;
    it.kind = k;
    it.slot = 3'(s);
    it.x = 16'(x);
    it.y = 16'(y);
    it.heading = 15'(h);
    return it;
  endfunction

  // mode 0: goal ahead, 1: at or behind goal, 2: arbitrary pose
  function automatic wgc_pkg::item_t make_pose(int mode);
    wgc_pkg::item_t it;
    real h, r;
    int hq, gi, dxi, dyi, nz;
    hq = int'($urandom_range(0, 25736)) - 12868;
    h = hq / 4096.0;
    gi = (sb.goal_idx < 8) ? sb.goal_idx : 0;
    if (mode == 2)
      return mk(wgc_pkg::ITEM_POSE, $urandom_range(0, 7), $urandom, $urandom, hq);
    if (mode == 1)
      r = real'($urandom_range(0, 500 + ((sb.arrive_thr < 2000) ? sb.arrive_thr : 2000)))
          - 500.0;
    else
      r = real'($urandom_range(64, 24000));
    dxi = int'(r * $cos(h));
    dyi = int'(r * $sin(h));
    if (mode == 0) begin
      nz = int'(r) / 8 + 1;
      dxi += $urandom_range(0, 2 * nz) - nz;
      dyi += $urandom_range(0, 2 * nz) - nz;
    end
    it = mk(wgc_pkg::ITEM_POSE, $urandom_range(0, 7), int'(sb.goal_x[gi]) - dxi,
            int'(sb.goal_y[gi]) - dyi, hq);
    return it;
  endfunction

  task send_item(wgc_pkg::item_t it);
    in_valid <= 1;
    in_low = 0;
    func <= it.kind;
    slot <= it.slot;
    coord_x <= it.x;
    coord_y <= it.y;
    heading <= it.heading;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      in_low = 1;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task settle();
    if (!in_low) begin
      in_valid <= 0;
      in_low = 1;
    end
    while (sb.expected_steer.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task cfg_write(wgc_pkg::cfg_idx_t idx, logic [15:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task run_random(int n, int s_idle, int r_idle);
    int pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        send_item(mk(wgc_pkg::ITEM_WRITE, $urandom_range(0, 7), $urandom, $urandom,
                     $urandom_range(0, 32767)));
      else if (pick < 16 && sb.goal_idx < 5)
        send_item(make_pose(2));
      else if (pick < 19 && sb.goal_idx < 6)
        send_item(make_pose(1));
      else
        send_item(make_pose(0));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_item(mk(wgc_pkg::ITEM_WRITE, 0, 32767, -32768, 0));
    send_item(mk(wgc_pkg::ITEM_WRITE, 1, -32768, 32767, 0));
    send_item(mk(wgc_pkg::ITEM_WRITE, 2, 0, 0, 0));
    send_item(mk(wgc_pkg::ITEM_WRITE, 3, 1000, 2000, 0));
    send_item(mk(wgc_pkg::ITEM_WRITE, 4, -4000, 300, 0));
    send_item(mk(wgc_pkg::ITEM_WRITE, 5, 25, -25, 0));
    send_item(mk(wgc_pkg::ITEM_WRITE, 6, 8000, 8000, 0));
    send_item(mk(wgc_pkg::ITEM_WRITE, 7, -8000, -1, 0));
    send_item(mk(wgc_pkg::ITEM_POSE, 0, -32768, 32767, 12868));
    send_item(mk(wgc_pkg::ITEM_POSE, 7, -32768, 32767, -12868));
    send_item(mk(wgc_pkg::ITEM_POSE, 0, 0, 0, 0));
    send_item(mk(wgc_pkg::ITEM_POSE, 0, 32767, 32767, 6434));
    send_item(mk(wgc_pkg::ITEM_POSE, 0, 32767, -32768, 100));
    send_item(mk(wgc_pkg::ITEM_POSE, 0, -32768, 32767, -3000));
    send_item(mk(wgc_pkg::ITEM_POSE, 0, 0, 0, 12868));
    send_item(mk(wgc_pkg::ITEM_POSE, 0, 0, 0, -12868));
    settle();

    // finished path, then reopen the list
    cfg_write(wgc_pkg::CFG_LAST_WP, 16'd0);
    send_item(mk(wgc_pkg::ITEM_POSE, 0, 100, 100, 0));
    settle();
    cfg_write(wgc_pkg::CFG_LAST_WP, 16'd7);
    cfg_write(wgc_pkg::CFG_THRESHOLD, 16'h7FFF);
    send_item(mk(wgc_pkg::ITEM_POSE, 0, 5000, -5000, 0));
    settle();
    cfg_write(wgc_pkg::CFG_THRESHOLD, 16'd0);
    cfg_write(wgc_pkg::CFG_LINEAR_GAIN, 16'hFFFF);
    cfg_write(wgc_pkg::CFG_ANGULAR_GAIN, 16'hFFFF);
    send_item(mk(wgc_pkg::ITEM_POSE, 0, -32768, -32768, 12868));
    send_item(make_pose(0));
    send_item(make_pose(0));
    run_random(280, 22, 60);
    settle();

    cfg_write(wgc_pkg::CFG_LINEAR_GAIN, 16'd0);
    cfg_write(wgc_pkg::CFG_ANGULAR_GAIN, 16'd0);
    cfg_write(wgc_pkg::CFG_THRESHOLD, 16'd100);
    send_item(make_pose(0));
    settle();
    cfg_write(wgc_pkg::CFG_LINEAR_GAIN, 16'($urandom));
    cfg_write(wgc_pkg::CFG_ANGULAR_GAIN, 16'($urandom));
    cfg_write(wgc_pkg::CFG_THRESHOLD, 16'd26);
    run_random(280, 60, 22);
    settle();

    cfg_write(wgc_pkg::CFG_LINEAR_GAIN, 16'd4096);
    cfg_write(wgc_pkg::CFG_ANGULAR_GAIN, 16'd3000);
    pressure_req = 1;
    run_random(280, 0, 0);
    settle();

    if (sb.fails == 0 && sb.expected_steer.size() == 0) begin
      $display("PASS waypoint_go_to_goal_controller_unit");
    end else begin
      $display("FAIL waypoint_go_to_goal_controller_unit");
    end
    $finish;
  end
endmodule
